@@ hdl/bitmap_slot_allocator_assert.svh @@
// Assertion macros for the bitmap slot allocator
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap slot allocator: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap slot allocator: check failed");

`endif

@@ hdl/bsa_pkg.sv @@
// Shared types and constants of the bitmap slot allocator
`default_nettype none

package bsa_pkg;

    localparam int MAX_SLOTS = 4096;
    localparam int WORD_BITS = 32;
    localparam int MAP_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WADDR_W   = $clog2(MAP_WORDS);
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 13;
    localparam int CMD_W     = 3;
    localparam int ST_W      = 2;

    localparam logic [CMD_W-1:0] CMD_FIND      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEALLOC   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MARK_USED = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MARK_FREE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SET_COUNT = 3'd7;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [ST_W-1:0] ST_CONFLICT = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] slot_index;
        logic [CNT_W-1:0] count_value;
    } bsa_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] found_index;
        logic             slot_used;
        logic [CNT_W-1:0] used_count;
        logic [ST_W-1:0]  status;
    } bsa_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd_slot;
        logic exec;
        logic finish;
    } bsa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_go;
        logic scan_hit;
        logic scan_miss;
    } bsa_stat_t;

endpackage

`default_nettype wire

@@ hdl/bsa_ctrl.sv @@
// Sequencing state machine of the bitmap slot allocator
`default_nettype none
`include "bitmap_slot_allocator_assert.svh"

module bsa_ctrl
    import bsa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    output bsa_cmd_t       cmd,
    input  wire bsa_stat_t stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_SCAN = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_slot = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.scan_go)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_hit || stat.scan_miss)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `BSA_ASSERT_IMP(a_finish_in_work, cmd.finish, (state_reg == S_EXEC) || (state_reg == S_SCAN))
    `BSA_ASSERT_NXT(a_accept_reads, start && !busy, state_reg == S_READ)
    `BSA_ASSERT_IMP(a_hit_ends_scan, (state_reg == S_SCAN) && stat.scan_hit, cmd.finish)
    `BSA_ASSERT_NXT(a_finish_frees, cmd.finish, !busy)

endmodule

`default_nettype wire

@@ hdl/bsa_dpath.sv @@
// Usage map, counters and word scan datapath of the bitmap slot allocator
`default_nettype none

module bsa_dpath
    import bsa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bsa_in_t          item,
    input  wire bsa_cmd_t         cmd,
    output bsa_stat_t             stat,
    input  wire logic             cfg_valid,
    input  wire logic [CNT_W-1:0] cfg_data,
    output bsa_out_t              result,
    output logic                  done
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);
    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    // Usage map with one valid bit per row; invalid rows read as zero
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] row_valid_reg;

    bsa_in_t              item_reg;
    logic [CNT_W-1:0]     size_reg;
    logic [CNT_W-1:0]     used_reg;
    logic [CNT_W-1:0]     used_next;
    logic [IDX_W-1:0]     pos_reg;
    logic [IDX_W-1:0]     pos_next;
    logic                 slot_bit_reg;

    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rvalid_reg;
    logic [WADDR_W-1:0]   raddr;

    logic                 we;
    logic [WORD_BITS-1:0] wdata;
    logic                 clear_all;

    logic [WADDR_W-1:0]   scan_addr_reg;
    logic                 scan_pass_reg;
    logic                 issue_reg;
    logic [WADDR_W-1:0]   chk_addr_reg;
    logic                 chk_pass_reg;
    logic                 chk_last_reg;
    logic                 chk_valid_reg;

    bsa_out_t             result_reg;
    bsa_out_t             result_next;
    logic                 done_reg;

    logic [CNT_W-1:0]     eff_size;
    logic [IDX_W-1:0]     size_m1;
    logic [IDX_W-1:0]     start_pos;
    logic [WADDR_W-1:0]   start_word;
    logic [BIT_W-1:0]     start_bit;
    logic [WADDR_W-1:0]   last_word;
    logic [BIT_W-1:0]     last_bit;

    logic [WORD_BITS-1:0] cur_word;
    logic [WADDR_W-1:0]   slot_word;
    logic [BIT_W-1:0]     slot_pos;
    logic                 slot_bit;
    logic                 slot_bit_new;
    logic                 in_range;
    logic [ST_W-1:0]      exec_status;
    logic                 need_scan;

    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] scan_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_W-1:0]     free_pos;

    // Effective size, clamped to 1..MAX_SLOTS
    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = CNT_W'(1);
        end
        else if (size_reg > MAX_CNT)
        begin
            eff_size = MAX_CNT;
        end
        else
        begin
            eff_size = size_reg;
        end
    end

    assign size_m1    = IDX_W'(eff_size - CNT_W'(1));
    assign start_pos  = ({1'b0, pos_reg} < eff_size) ? pos_reg : '0;
    assign start_word = start_pos[IDX_W-1:BIT_W];
    assign start_bit  = start_pos[BIT_W-1:0];
    assign last_word  = size_m1[IDX_W-1:BIT_W];
    assign last_bit   = size_m1[BIT_W-1:0];

    assign slot_word  = item_reg.slot_index[IDX_W-1:BIT_W];
    assign slot_pos   = item_reg.slot_index[BIT_W-1:0];
    assign cur_word   = rvalid_reg ? rdata_reg : '0;
    assign slot_bit   = cur_word[slot_pos];
    assign in_range   = ({1'b0, item_reg.slot_index} < eff_size);
    assign need_scan  = (item_reg.command == CMD_FIND) && (used_reg < eff_size);

    assign raddr = cmd.rd_slot ? slot_word : scan_addr_reg;

    // Command execution on the word read for slot_index
    always_comb
    begin
        used_next    = used_reg;
        pos_next     = pos_reg;
        we           = 1'b0;
        wdata        = cur_word;
        clear_all    = 1'b0;
        slot_bit_new = slot_bit;
        exec_status  = ST_OK;
        case (item_reg.command)
            CMD_FIND:
            begin
                if (!need_scan)
                begin
                    exec_status = ST_NO_FREE;
                end
            end
            CMD_ALLOC:
            begin
                if (!in_range)
                begin
                    exec_status = ST_RANGE;
                end
                else if (slot_bit)
                begin
                    exec_status = ST_CONFLICT;
                end
                else
                begin
                    we              = 1'b1;
                    wdata[slot_pos] = 1'b1;
                    slot_bit_new    = 1'b1;
                    if ({1'b0, item_reg.slot_index} + CNT_W'(1) == eff_size)
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        pos_next = item_reg.slot_index + IDX_W'(1);
                    end
                    if (used_reg < MAX_CNT)
                    begin
                        used_next = used_reg + CNT_W'(1);
                    end
                end
            end
            CMD_DEALLOC:
            begin
                if (!in_range)
                begin
                    exec_status = ST_RANGE;
                end
                else if (!slot_bit)
                begin
                    exec_status = ST_CONFLICT;
                end
                else
                begin
                    we              = 1'b1;
                    wdata[slot_pos] = 1'b0;
                    slot_bit_new    = 1'b0;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - CNT_W'(1);
                    end
                end
            end
            CMD_MARK_USED,
            CMD_MARK_FREE:
            begin
                if (!in_range)
                begin
                    exec_status = ST_RANGE;
                end
                else
                begin
                    we              = 1'b1;
                    slot_bit_new    = (item_reg.command == CMD_MARK_USED);
                    wdata[slot_pos] = slot_bit_new;
                end
            end
            CMD_QUERY:
            begin
                if (!in_range)
                begin
                    exec_status = ST_RANGE;
                end
            end
            CMD_CLEAR:
            begin
                clear_all    = 1'b1;
                slot_bit_new = 1'b0;
                pos_next     = '0;
                used_next    = '0;
            end
            CMD_SET_COUNT:
            begin
                if (item_reg.count_value > eff_size)
                begin
                    exec_status = ST_RANGE;
                end
                else
                begin
                    used_next = item_reg.count_value;
                end
            end
            default:
            begin
                exec_status = ST_OK;
            end
        endcase
    end

    // Free bits of the checked word inside the scan window of its pass
    always_comb
    begin
        lo_mask = ONES;
        hi_mask = ONES;
        if (!chk_pass_reg)
        begin
            if (chk_addr_reg == start_word)
            begin
                lo_mask = ONES << start_bit;
            end
            if (chk_addr_reg == last_word)
            begin
                hi_mask = ONES >> (BIT_W'(WORD_BITS - 1) - last_bit);
            end
        end
        else if (chk_addr_reg == start_word)
        begin
            hi_mask = ~(ONES << start_bit);
        end
        scan_mask = lo_mask & hi_mask;
        free_bits = ~cur_word & scan_mask;
    end

    // Lowest free bit
    always_comb
    begin
        free_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                free_pos = BIT_W'(b);
            end
        end
    end

    assign stat.scan_go   = need_scan;
    assign stat.scan_hit  = chk_valid_reg && (free_bits != '0);
    assign stat.scan_miss = chk_valid_reg && chk_last_reg && (free_bits == '0);

    always_comb
    begin
        if (cmd.exec)
        begin
            result_next.found_index = '0;
            result_next.slot_used   = slot_bit_new;
            result_next.used_count  = used_next;
            result_next.status      = exec_status;
        end
        else
        begin
            result_next.found_index = stat.scan_hit ? {chk_addr_reg, free_pos} : '0;
            result_next.slot_used   = slot_bit_reg;
            result_next.used_count  = used_reg;
            result_next.status      = stat.scan_hit ? ST_OK : ST_NO_FREE;
        end
    end

    // Map storage: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.exec && we)
        begin
            map_mem[slot_word] <= wdata;
        end
        rdata_reg  <= map_mem[raddr];
        rvalid_reg <= row_valid_reg[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            size_reg      <= MAX_CNT;
            used_reg      <= '0;
            pos_reg       <= '0;
            issue_reg     <= 1'b0;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cfg_valid)
            begin
                size_reg <= cfg_data;
            end
            if (cmd.exec)
            begin
                used_reg <= used_next;
                pos_reg  <= pos_next;
                if (clear_all)
                begin
                    row_valid_reg <= '0;
                end
                else if (we)
                begin
                    row_valid_reg[slot_word] <= 1'b1;
                end
            end
            // Scan pipeline: issue a word read, check the registered word in the next cycle
            if (cmd.load)
            begin
                issue_reg     <= 1'b0;
                chk_valid_reg <= 1'b0;
            end
            else if (cmd.exec)
            begin
                issue_reg     <= need_scan;
                chk_valid_reg <= 1'b0;
            end
            else
            begin
                chk_valid_reg <= issue_reg;
                if (issue_reg && scan_pass_reg && (scan_addr_reg == start_word))
                begin
                    issue_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.exec)
        begin
            slot_bit_reg  <= slot_bit_new;
            scan_addr_reg <= start_word;
            scan_pass_reg <= 1'b0;
        end
        else if (issue_reg)
        begin
            if (!scan_pass_reg && (scan_addr_reg == last_word))
            begin
                scan_addr_reg <= '0;
                scan_pass_reg <= 1'b1;
            end
            else
            begin
                scan_addr_reg <= scan_addr_reg + WADDR_W'(1);
            end
        end
        chk_addr_reg <= scan_addr_reg;
        chk_pass_reg <= scan_pass_reg;
        chk_last_reg <= scan_pass_reg && (scan_addr_reg == start_word);
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

@@ hdl/bitmap_slot_allocator.sv @@
// Top level of the next-fit bitmap slot allocator
//
//  channel   | ports                      | transaction
//  ----------+----------------------------+------------------------------------
//  command   | start, busy, item          | start high while busy low
//  result    | done, result               | one cycle, done high, no backpressure
//  config    | cfg_valid, cfg_ready, cfg_data | cfg_valid and cfg_ready high
//
// Every command but find, and find when the used count leaves no slot free, passes from
// acceptance through a read of the map word of slot_index, an execute step and the result register.
// Find then scans one map word per cycle through the registered map read port:
// up to (active_size-1)/32 + 2 word reads.
// A new command is accepted in the cycle the previous result is shown.
// Reset clears the map through per-row valid bits at once; no clearing pass.
`default_nettype none

module bitmap_slot_allocator
    import bsa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire bsa_in_t          item,
    output logic                  done,
    output bsa_out_t              result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data
);

    bsa_cmd_t  cmd;
    bsa_stat_t stat;

    assign cfg_ready = 1'b1;

    bsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    bsa_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .result    (result),
        .done      (done)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the next-fit bitmap slot allocator
module tb;
    import bsa_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    bsa_in_t          item = '0;
    logic             done;
    bsa_out_t         result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;

    // Shadow state of the allocator
    logic [MAX_SLOTS-1:0] slot_map = '0;
    logic [IDX_W-1:0]     fit_pos = '0;
    logic [CNT_W-1:0]     used_total = '0;
    logic [CNT_W-1:0]     size_setting = CNT_W'(MAX_SLOTS);

    bsa_out_t pending_results[$];
    bsa_out_t oldest;
    int       error_count = 0;
    bit       steady_flow = 1'b0;

    bitmap_slot_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("bitmap_slot_allocator: mismatch");
        $finish;
    end

    function automatic int slot_span();
        int sz;
        sz = int'(size_setting);
        if (sz < 1) sz = 1;
        if (sz > MAX_SLOTS) sz = MAX_SLOTS;
        return sz;
    endfunction

    // Apply one command to the shadow state and return the result it must give
    function automatic bsa_out_t apply_command(bsa_in_t c);
        bsa_out_t r;
        int sz;
        int slot;
        int origin;
        int first_free;
        sz = slot_span();
        slot = int'(c.slot_index);
        first_free = -1;
        r = '0;
        case (c.command)
            CMD_FIND:
            begin
                origin = (int'(fit_pos) < sz) ? int'(fit_pos) : 0;
                if (int'(used_total) < sz)
                begin
                    for (int i = origin; i < sz && first_free < 0; i++)
                        if (!slot_map[i]) first_free = i;
                    for (int i = 0; i < origin && first_free < 0; i++)
                        if (!slot_map[i]) first_free = i;
                end
                if (first_free < 0) r.status = ST_NO_FREE;
                else r.found_index = IDX_W'(first_free);
            end
            CMD_ALLOC:
            begin
                if (slot >= sz) r.status = ST_RANGE;
                else if (slot_map[slot]) r.status = ST_CONFLICT;
                else
                begin
                    slot_map[slot] = 1'b1;
                    fit_pos = IDX_W'((slot + 1) % sz);
                    if (int'(used_total) < MAX_SLOTS) used_total = used_total + 1'b1;
                end
            end
            CMD_DEALLOC:
            begin
                if (slot >= sz) r.status = ST_RANGE;
                else if (!slot_map[slot]) r.status = ST_CONFLICT;
                else
                begin
                    slot_map[slot] = 1'b0;
                    if (used_total != 0) used_total = used_total - 1'b1;
                end
            end
            CMD_MARK_USED, CMD_MARK_FREE:
            begin
                if (slot >= sz) r.status = ST_RANGE;
                else slot_map[slot] = (c.command == CMD_MARK_USED);
            end
            CMD_QUERY:
            begin
                if (slot >= sz) r.status = ST_RANGE;
            end
            CMD_CLEAR:
            begin
                slot_map = '0;
                fit_pos = '0;
                used_total = '0;
            end
            default:
            begin
                if (int'(c.count_value) > sz) r.status = ST_RANGE;
                else used_total = c.count_value;
            end
        endcase
        r.slot_used = slot_map[slot];
        r.used_count = used_total;
        return r;
    endfunction

    function automatic int idle_cycles();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic flag_error(input string field, input int want, input int got);
        error_count++;
        if (error_count <= 10)
            $display("result error: %s expected %0d actual %0d", field, want, got);
    endtask

    // Check every strobed result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                flag_error("unexpected transaction", 0, 1);
            else
            begin
                oldest = pending_results.pop_front();
                if (result.found_index !== oldest.found_index)
                    flag_error("found_index", oldest.found_index, result.found_index);
                if (result.slot_used !== oldest.slot_used)
                    flag_error("slot_used", oldest.slot_used, result.slot_used);
                if (result.used_count !== oldest.used_count)
                    flag_error("used_count", oldest.used_count, result.used_count);
                if (result.status !== oldest.status)
                    flag_error("status", oldest.status, result.status);
            end
        end
    end

    // Issue one command; keep start high when the next one follows at once
    task automatic send_command(input logic [CMD_W-1:0] op, input int slot, input int cnt,
                                output bsa_out_t predicted);
        bsa_in_t c;
        int pause;
        c.command = op;
        c.slot_index = IDX_W'(slot);
        c.count_value = CNT_W'(cnt);
        item <= c;
        if (!start) start <= 1'b1;
        do @(posedge clk); while (busy);
        predicted = apply_command(c);
        pending_results.push_back(predicted);
        pause = idle_cycles();
        if (pause > 0)
        begin
            start <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    task automatic send(input logic [CMD_W-1:0] op, input int slot, input int cnt);
        bsa_out_t ignored;
        send_command(op, slot, cnt, ignored);
    endtask

    task automatic wait_idle();
        if (start) start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_size(input int value);
        wait_idle();
        cfg_data <= CNT_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_setting = CNT_W'(value);
    endtask

    task automatic test_after_reset();
        send(CMD_QUERY, MAX_SLOTS - 1, 0);
        send(CMD_FIND, 0, 0);
        send(CMD_DEALLOC, 5, 0);
    endtask

    task automatic test_basic_commands();
        send(CMD_ALLOC, 0, 0);
        send(CMD_ALLOC, 0, 0);
        send(CMD_FIND, 0, 0);
        send(CMD_ALLOC, MAX_SLOTS - 1, 0);
        send(CMD_MARK_USED, 7, 0);
        send(CMD_QUERY, 7, 0);
        send(CMD_MARK_FREE, 7, 0);
        send(CMD_DEALLOC, MAX_SLOTS - 1, 0);
    endtask

    task automatic test_count_limits();
        send(CMD_SET_COUNT, 0, MAX_SLOTS);
        send(CMD_FIND, 0, 0);
        send(CMD_ALLOC, 9, 0);
        send(CMD_SET_COUNT, 0, (1 << CNT_W) - 1);
        send(CMD_CLEAR, 0, 0);
        // count is zero here, so the dealloc must not wrap it
        send(CMD_MARK_USED, 3, 0);
        send(CMD_DEALLOC, 3, 0);
    endtask

    task automatic test_size_changes();
        send(CMD_ALLOC, 100, 0);
        // position 101 is stale once the map shrinks to 8 slots
        write_size(8);
        send(CMD_FIND, 0, 0);
        send(CMD_ALLOC, 8, 0);
        send(CMD_QUERY, 100, 0);
        send(CMD_SET_COUNT, 0, 9);
        // one slot, marked used, with the count already equal to the size
        write_size(1);
        send(CMD_MARK_USED, 0, 0);
        send(CMD_FIND, 0, 0);
        write_size(0);
        send(CMD_QUERY, 0, 0);
        write_size((1 << CNT_W) - 1);
        send(CMD_FIND, 0, 0);
        send(CMD_CLEAR, 0, 0);
    endtask

    function automatic logic [CMD_W-1:0] CMD_CMD_W_NOISE();
        return CMD_W'($urandom_range(0, 7));
    endfunction

    task automatic run_random_phase(input int size_value, input int n_items);
        bsa_out_t res;
        int sz;
        int pick;
        int slot;
        write_size(size_value);
        sz = slot_span();
        for (int k = 0; k < n_items; k++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) slot = $urandom_range(0, MAX_SLOTS - 1);
            else slot = $urandom_range(0, sz - 1);
            if (pick < 30)
            begin
                send_command(CMD_FIND, slot, $urandom_range(0, 8191), res);
                if (res.status == ST_OK)
                begin
                    send(CMD_ALLOC, int'(res.found_index), $urandom_range(0, 8191));
                    k++;
                end
            end
            else if (pick < 45)
                send(CMD_ALLOC, slot, $urandom_range(0, 8191));
            else if (pick < 60)
            begin
                // advance to a used slot so most deallocs succeed
                for (int j = 0; j < sz && (slot >= sz || !slot_map[slot]); j++)
                    slot = (slot + 1) % sz;
                send(CMD_DEALLOC, slot, $urandom_range(0, 8191));
            end
            else if (pick < 68)
                send(pick[0] ? CMD_MARK_USED : CMD_MARK_FREE, slot, $urandom_range(0, 8191));
            else if (pick < 76)
                send(CMD_QUERY, slot, $urandom_range(0, 8191));
            else if (pick < 81)
                send(CMD_SET_COUNT, slot,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(0, sz));
            else if (pick < 83)
                send(CMD_CLEAR, slot, $urandom_range(0, 8191));
            else
                send(CMD_CMD_W_NOISE(), $urandom_range(0, MAX_SLOTS - 1),
                     $urandom_range(0, 8191));
        end
    endtask

    task automatic test_random_traffic();
        int sizes[10];
        sizes = '{8, 4096, 1, 33, 200, 0, 64, 8191, 500, 16};
        for (int p = 0; p < 10; p++)
        begin
            steady_flow = (p % 3 == 1);
            run_random_phase(sizes[p], 115);
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_basic_commands();
        test_count_limits();
        test_size_changes();
        test_random_traffic();
        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("bitmap_slot_allocator: match");
        else
            $display("bitmap_slot_allocator: mismatch");
        $finish;
    end

endmodule
